FILE: sv/palette_index_2bpp_packer_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the palette index packer
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef PALETTE_INDEX_2BPP_PACKER_TOP_ASSERT_SVH
`define PALETTE_INDEX_2BPP_PACKER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PI2P_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication
`define PI2P_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`else

`define PI2P_ASSERT_NOW(label, clk, rst, cond, expr, msg)
`define PI2P_ASSERT_NEXT(label, clk, rst, cond, expr, msg)

`endif

`endif

FILE: sv/pi2p_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Palette index packer package
// Shared widths and the status structs passed between the units.
// ---------------------------------------------------------------------------
package pi2p_pkg;

   localparam int PIXEL_BITS_DEFAULT = 32;
   localparam int COLOUR_W           = 32;
   localparam int PAL_DEPTH          = 4;
   localparam int IDX_W              = 2;
   localparam int COUNT_W            = 3;
   localparam int BYTE_W             = 8;

   // palette lookup result for the pixel in flight
   typedef struct packed {
      logic [IDX_W-1:0]   idx;       // index given to the pixel
      logic [COUNT_W-1:0] count;     // entries after this pixel
      logic               overflow;  // sticky overflow after this pixel
   } pal_status_type;

   // packer decision for the pixel in flight
   typedef struct packed {
      logic              emit;
      logic [BYTE_W-1:0] packed_byte;
      logic              byte_valid;
      logic              image_done;
   } pack_result_type;

endpackage

FILE: sv/pi2p_palette.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Palette unit
// Four-way parallel match against the stored colours, allocation of a new
// entry in order of first sight, and the sticky overflow flag.
// ---------------------------------------------------------------------------
module pi2p_palette
   import pi2p_pkg::*;
#(
   parameter int PIXEL_BITS = PIXEL_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  logic                                 last_pixel,
   input  logic [PIXEL_BITS-1:0]                colour,
   output pal_status_type                       status,
   output logic [PAL_DEPTH-1:0][PIXEL_BITS-1:0] entries_next
);

   logic [PAL_DEPTH-1:0][PIXEL_BITS-1:0] entry_ff, entry_in;
   logic [COUNT_W-1:0]                   count_ff, count_in;
   logic                                 ovf_ff, ovf_in;
   logic [PAL_DEPTH-1:0]                 match;
   logic                                 hit;
   logic                                 alloc;
   logic [IDX_W-1:0]                     hit_idx;
   logic [COUNT_W-1:0]                   count_next;
   logic                                 ovf_next;

   always_comb begin
      for (int k = 0; k < PAL_DEPTH; k++) begin
         match[k] = (COUNT_W'(k) < count_ff) && (entry_ff[k] == colour);
      end
   end

   // lowest matching entry wins
   always_comb begin
      hit_idx = '0;
      for (int k = PAL_DEPTH - 1; k >= 0; k--) begin
         if (match[k]) begin
            hit_idx = IDX_W'(k);
         end
      end
   end

   assign hit   = |match;
   assign alloc = !hit && !count_ff[COUNT_W-1];

   always_comb begin
      for (int k = 0; k < PAL_DEPTH; k++) begin
         entry_in[k]     = entry_ff[k];
         entries_next[k] = (alloc && (count_ff[IDX_W-1:0] == IDX_W'(k))) ? colour
                                                                       : entry_ff[k];
      end
      count_next = alloc ? count_ff + COUNT_W'(1) : count_ff;
      ovf_next   = ovf_ff || (!hit && count_ff[COUNT_W-1]);
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      if (step) begin
         if (last_pixel) begin
            entry_in = '0;
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            entry_in = entries_next;
            count_in = count_next;
            ovf_in   = ovf_next;
         end
      end
   end

   always_comb begin
      status.idx      = hit ? hit_idx : (alloc ? count_ff[IDX_W-1:0] : '0);
      status.count    = count_next;
      status.overflow = ovf_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

FILE: sv/pi2p_packer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Crumb packer
// Places each 2-bit index into the byte under assembly, first pixel at the
// top, and decides when a byte goes out.
// ---------------------------------------------------------------------------
module pi2p_packer
   import pi2p_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic            last_pixel,
   input  pal_status_type  status,
   output pack_result_type result
);

   logic [IDX_W-1:0]  crumb_ff, crumb_in;
   logic [BYTE_W-1:0] partial_ff, partial_in;
   logic [BYTE_W-1:0] partial_new;
   logic [2:0]        shift;
   logic              full;

   // 6 - 2*position
   assign shift       = 3'(BYTE_W - IDX_W) - {crumb_ff, 1'b0};
   assign partial_new = partial_ff | (BYTE_W'(status.idx) << shift);
   assign full        = &crumb_ff;

   always_comb begin
      result.emit        = last_pixel || (full && !status.overflow);
      result.byte_valid  = !status.overflow;
      result.image_done  = last_pixel;
      result.packed_byte = status.overflow ? '0 : partial_new;
   end

   always_comb begin
      crumb_in   = crumb_ff;
      partial_in = partial_ff;
      if (step) begin
         if (last_pixel) begin
            crumb_in   = '0;
            partial_in = '0;
         end else begin
            crumb_in   = crumb_ff + IDX_W'(1);
            partial_in = full ? '0 : partial_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crumb_ff   <= '0;
         partial_ff <= '0;
      end else begin
         crumb_ff   <= crumb_in;
         partial_ff <= partial_in;
      end
   end

endmodule

FILE: sv/palette_index_2bpp_packer_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Palette index 2bpp packer, top level
// Builds a four-color palette from a pixel stream and packs 2-bit indices.
// ---------------------------------------------------------------------------
// Each request carries one pixel color (only the low PIXEL_BITS bits count)
// and a last_pixel mark. Colors get palette indices 0..3 in order of first
// appearance; four indices fill one byte, first pixel in bits 7:6, and the
// byte is returned on the rsp channel with the current palette and color
// count. The last pixel always yields one response with image_done set: the
// byte is flushed zero-padded, and then palette, count and packing state are
// cleared for the next image. A fifth distinct color raises a sticky
// too_many_colours flag; bytes are then withheld until the last pixel, whose
// response carries byte_valid low and a zero byte. Throughput is one request
// per clock while responses are not stalled. An accepted request waits in
// the input register; the palette compare and packing run between that
// register and the response register, which loads when the pixel steps on,
// and the response is offered from there. While a finished
// response is stalled, one more request is taken into the input register;
// further requests stall until the response is taken, whether or not the
// waiting pixel produces a response of its own.
// ---------------------------------------------------------------------------
module palette_index_2bpp_packer_top
   import pi2p_pkg::*;
#(
   parameter int PIXEL_BITS = PIXEL_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [COLOUR_W-1:0] req_pixel_colour,
   input  logic                req_last_pixel,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [BYTE_W-1:0]   rsp_packed_byte,
   output logic                rsp_byte_valid,
   output logic                rsp_image_done,
   output logic                rsp_too_many_colours,
   output logic [COUNT_W-1:0]  rsp_colours_used,
   output logic [COLOUR_W-1:0] rsp_palette_zero,
   output logic [COLOUR_W-1:0] rsp_palette_one,
   output logic [COLOUR_W-1:0] rsp_palette_two,
   output logic [COLOUR_W-1:0] rsp_palette_three
);

   // input register
   logic                  s1_valid_ff, s1_valid_in;
   logic [PIXEL_BITS-1:0] s1_colour_ff;
   logic                  s1_last_ff;
   logic                  req_accept;
   logic                  out_free;
   logic                  s1_go;

   // datapath between the registers
   pal_status_type                       pal_status;
   logic [PAL_DEPTH-1:0][PIXEL_BITS-1:0] pal_entries;
   pack_result_type                      pack_result;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_byte_ff;
   logic                rsp_byte_valid_ff;
   logic                rsp_done_ff;
   logic                rsp_ovf_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic [PAL_DEPTH-1:0][COLOUR_W-1:0] rsp_pal_ff;

   // handshake: the pixel in the input register moves on whenever the
   // response register is empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_go      = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_colour_ff <= req_pixel_colour[PIXEL_BITS-1:0];
         s1_last_ff   <= req_last_pixel;
      end
   end

   pi2p_palette #(
      .PIXEL_BITS(PIXEL_BITS)
   ) u_palette (
      .clock        (clock),
      .reset        (reset),
      .step         (s1_go),
      .last_pixel   (s1_last_ff),
      .colour       (s1_colour_ff),
      .status       (pal_status),
      .entries_next (pal_entries)
   );

   pi2p_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .step       (s1_go),
      .last_pixel (s1_last_ff),
      .status     (pal_status),
      .result     (pack_result)
   );

   // response register: loads when a pixel steps and produces a byte
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff && pack_result.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && pack_result.emit) begin
         rsp_byte_ff       <= pack_result.packed_byte;
         rsp_byte_valid_ff <= pack_result.byte_valid;
         rsp_done_ff       <= pack_result.image_done;
         rsp_ovf_ff        <= pal_status.overflow;
         rsp_count_ff      <= pal_status.count;
         for (int k = 0; k < PAL_DEPTH; k++) begin
            rsp_pal_ff[k] <= COLOUR_W'(pal_entries[k]);
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_packed_byte      = rsp_byte_ff;
   assign rsp_byte_valid       = rsp_byte_valid_ff;
   assign rsp_image_done       = rsp_done_ff;
   assign rsp_too_many_colours = rsp_ovf_ff;
   assign rsp_colours_used     = rsp_count_ff;
   assign rsp_palette_zero     = rsp_pal_ff[0];
   assign rsp_palette_one      = rsp_pal_ff[1];
   assign rsp_palette_two      = rsp_pal_ff[2];
   assign rsp_palette_three    = rsp_pal_ff[3];

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
`include "palette_index_2bpp_packer_top_assert.svh"

   // an overflowed image only ever answers on its last pixel
   `PI2P_ASSERT_NOW(a_ovf_only_on_done, clock, reset, rsp_valid && rsp_too_many_colours, rsp_image_done && !rsp_byte_valid, "overflow response outside image end")

   // bytes carry data whenever no overflow is flagged
   `PI2P_ASSERT_NOW(a_byte_valid_no_ovf, clock, reset, rsp_valid && !rsp_too_many_colours, rsp_byte_valid, "byte_valid low without overflow")

   // the palette starts over after the last pixel steps
   `PI2P_ASSERT_NEXT(a_clear_after_last, clock, reset, s1_go && s1_last_ff, !s1_valid_ff || (pal_status.count <= COUNT_W'(1)), "palette not cleared after last pixel")

   // the request side only stalls with a pixel waiting
   `PI2P_ASSERT_NOW(a_stall_has_pixel, clock, reset, req_stall, s1_valid_ff && rsp_valid_ff, "request stall with empty pipeline")

endmodule

FILE: dv/palette_index_2bpp_packer_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Palette index packer response checker
// Watches both channels, keeps its own palette and packing state, and
// compares every response against the oldest prediction.
// ---------------------------------------------------------------------------
module palette_index_2bpp_packer_checker
   import pi2p_pkg::*;
#(
   parameter int PIXEL_BITS = PIXEL_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [COLOUR_W-1:0] req_pixel_colour,
   input  logic                req_last_pixel,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [BYTE_W-1:0]   rsp_packed_byte,
   input  logic                rsp_byte_valid,
   input  logic                rsp_image_done,
   input  logic                rsp_too_many_colours,
   input  logic [COUNT_W-1:0]  rsp_colours_used,
   input  logic [COLOUR_W-1:0] rsp_palette_zero,
   input  logic [COLOUR_W-1:0] rsp_palette_one,
   input  logic [COLOUR_W-1:0] rsp_palette_two,
   input  logic [COLOUR_W-1:0] rsp_palette_three,
   output int                  error_count,
   output int                  pending_count,
   output int                  response_count
);

   localparam logic [COLOUR_W-1:0] COLOUR_MASK = {COLOUR_W{1'b1}} >> (COLOUR_W - PIXEL_BITS);
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [BYTE_W-1:0]   packed_byte;
      logic                byte_valid;
      logic                image_done;
      logic                too_many_colours;
      logic [COUNT_W-1:0]  colours_used;
      logic [COLOUR_W-1:0] pal_zero;
      logic [COLOUR_W-1:0] pal_one;
      logic [COLOUR_W-1:0] pal_two;
      logic [COLOUR_W-1:0] pal_three;
   } pixel_response_type;

   logic [COLOUR_W-1:0] palette [PAL_DEPTH];
   logic [COUNT_W-1:0]  entries;
   logic [1:0]          crumb;
   logic [BYTE_W-1:0]   partial;
   logic                overflow;

   pixel_response_type  awaited_responses[$];
   int                  errors;
   int                  checked;

   function automatic pixel_response_type snapshot(input logic [BYTE_W-1:0] b,
                                                   input logic valid, input logic done);
      pixel_response_type r;
      r.packed_byte      = b;
      r.byte_valid       = valid;
      r.image_done       = done;
      r.too_many_colours = overflow;
      r.colours_used     = entries;
      r.pal_zero         = palette[0];
      r.pal_one          = palette[1];
      r.pal_two          = palette[2];
      r.pal_three        = palette[3];
      return r;
   endfunction

   function automatic string show(input pixel_response_type r);
      return $sformatf("byte=%h valid=%b done=%b over=%b used=%0d palette=%h %h %h %h",
                       r.packed_byte, r.byte_valid, r.image_done, r.too_many_colours,
                       r.colours_used, r.pal_zero, r.pal_one, r.pal_two, r.pal_three);
   endfunction

   task automatic clear_image();
      for (int k = 0; k < PAL_DEPTH; k++) palette[k] = '0;
      entries  = '0;
      crumb    = '0;
      partial  = '0;
      overflow = 1'b0;
   endtask

   // palette lookup, crumb insert, and the emit decision for one pixel
   task automatic index_pixel(input logic [COLOUR_W-1:0] raw, input logic last);
      logic [COLOUR_W-1:0] colour;
      logic [IDX_W-1:0]    idx;
      logic                hit;
      logic                full;
      logic [BYTE_W-1:0]   done_byte;
      int                  shift;
      colour = raw & COLOUR_MASK;
      idx    = '0;
      hit    = 1'b0;
      for (int k = 0; k < PAL_DEPTH; k++) begin
         if (k < entries && palette[k] == colour && !hit) begin
            idx = IDX_W'(k);
            hit = 1'b1;
         end
      end
      if (!hit) begin
         if (entries < PAL_DEPTH) begin
            palette[entries[IDX_W-1:0]] = colour;
            idx     = entries[IDX_W-1:0];
            entries = entries + 1'b1;
         end else begin
            overflow = 1'b1;   // palette stays as is, index reads as zero
            idx      = '0;
         end
      end
      shift   = 6 - 2 * int'(crumb);
      partial = partial | (BYTE_W'(idx) << shift);
      full    = (crumb == 2'd3);
      crumb   = crumb + 2'd1;
      if (last) begin
         if (overflow) awaited_responses.push_back(snapshot('0, 1'b0, 1'b1));
         else awaited_responses.push_back(snapshot(partial, 1'b1, 1'b1));
         clear_image();
      end else if (full) begin
         done_byte = partial;
         partial   = '0;
         if (!overflow) awaited_responses.push_back(snapshot(done_byte, 1'b1, 1'b0));
      end
   endtask

   always @(posedge clock) begin
      pixel_response_type seen;
      pixel_response_type want;
      if (reset) begin
         clear_image();
         awaited_responses.delete();
         errors  = 0;
         checked = 0;
      end else begin
         // predict first: a response never belongs to a request of the same edge
         if (req_valid && !req_stall) index_pixel(req_pixel_colour, req_last_pixel);
         if (rsp_valid && !rsp_stall) begin
            seen.packed_byte      = rsp_packed_byte;
            seen.byte_valid       = rsp_byte_valid;
            seen.image_done       = rsp_image_done;
            seen.too_many_colours = rsp_too_many_colours;
            seen.colours_used     = rsp_colours_used;
            seen.pal_zero         = rsp_palette_zero;
            seen.pal_one          = rsp_palette_one;
            seen.pal_two          = rsp_palette_two;
            seen.pal_three        = rsp_palette_three;
            checked++;
            if (awaited_responses.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("ERROR: unexpected response at %0t: %s", $realtime, show(seen));
            end else begin
               want = awaited_responses.pop_front();
               if (seen !== want) begin
                  errors++;
                  if (errors <= REPORT_LIMIT) begin
                     $display("ERROR: response %0d mismatch at %0t", checked, $realtime);
                     $display("   expected %s", show(want));
                     $display("   actual   %s", show(seen));
                  end
               end
            end
         end
      end
      error_count    <= errors;
      pending_count  <= awaited_responses.size();
      response_count <= checked;
   end

endmodule

FILE: dv/palette_index_2bpp_packer_top_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Palette index packer testbench
// Streams images through the packer with random gaps and response stalls;
// a side checker predicts every response and counts mismatches.
// ---------------------------------------------------------------------------
module palette_index_2bpp_packer_top_test;
   import pi2p_pkg::*;

   localparam int PIXEL_TARGET = 1700;  // stop starting new images past this
   localparam int IDLE_LIMIT   = 4000;  // cycles with no handshake on either side
   localparam int DRAIN_CYCLES = 20;    // settle time after the last response

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [COLOUR_W-1:0] req_pixel_colour = '0;
   logic                req_last_pixel = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [BYTE_W-1:0]   rsp_packed_byte;
   logic                rsp_byte_valid;
   logic                rsp_image_done;
   logic                rsp_too_many_colours;
   logic [COUNT_W-1:0]  rsp_colours_used;
   logic [COLOUR_W-1:0] rsp_palette_zero;
   logic [COLOUR_W-1:0] rsp_palette_one;
   logic [COLOUR_W-1:0] rsp_palette_two;
   logic [COLOUR_W-1:0] rsp_palette_three;

   int errors;
   int pending;
   int responses;
   int pixels_sent = 0;
   int images_sent = 0;
   int idle_cycles = 0;

   always #2 clock = ~clock;

   palette_index_2bpp_packer_top uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_pixel_colour     (req_pixel_colour),
      .req_last_pixel       (req_last_pixel),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_packed_byte      (rsp_packed_byte),
      .rsp_byte_valid       (rsp_byte_valid),
      .rsp_image_done       (rsp_image_done),
      .rsp_too_many_colours (rsp_too_many_colours),
      .rsp_colours_used     (rsp_colours_used),
      .rsp_palette_zero     (rsp_palette_zero),
      .rsp_palette_one      (rsp_palette_one),
      .rsp_palette_two      (rsp_palette_two),
      .rsp_palette_three    (rsp_palette_three)
   );

   // Checker sits beside the block, sees the same pins, reports counts back.
   palette_index_2bpp_packer_checker pack_monitor (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_pixel_colour     (req_pixel_colour),
      .req_last_pixel       (req_last_pixel),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_packed_byte      (rsp_packed_byte),
      .rsp_byte_valid       (rsp_byte_valid),
      .rsp_image_done       (rsp_image_done),
      .rsp_too_many_colours (rsp_too_many_colours),
      .rsp_colours_used     (rsp_colours_used),
      .rsp_palette_zero     (rsp_palette_zero),
      .rsp_palette_one      (rsp_palette_one),
      .rsp_palette_two      (rsp_palette_two),
      .rsp_palette_three    (rsp_palette_three),
      .error_count          (errors),
      .pending_count        (pending),
      .response_count       (responses)
   );

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // One pixel request. Valid stays high across back-to-back requests, so
   // it is only lowered when a gap is actually inserted.
   task automatic send_pixel(input logic [COLOUR_W-1:0] colour, input logic last,
                             input bit steady);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_pixel_colour <= colour;
      req_last_pixel   <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
      if (last) images_sent++;
   endtask

   // Random image drawn from a small color set. Sets larger than the
   // palette exercise the sticky overflow; near-miss colors (one bit off
   // the first entry) make sure the compare looks at every bit.
   task automatic send_image(input int length, input int distinct);
      logic [COLOUR_W-1:0] colours [8];
      bit                  steady;
      steady = ($urandom_range(0, 4) == 0);   // some images run without gaps
      for (int i = 0; i < distinct; i++) begin
         case ($urandom_range(0, 5))
            0: colours[i] = '0;
            1: colours[i] = '1;
            2: colours[i] = (i > 0) ? colours[0] ^ (COLOUR_W'(1) << $urandom_range(0, COLOUR_W-1))
                                    : $urandom();
            default: colours[i] = $urandom();
         endcase
      end
      for (int i = 0; i < length; i++)
         send_pixel(colours[$urandom_range(0, distinct-1)], (i == length-1), steady);
   endtask

   // Response side: stall runs alternate with free runs, some of them long.
   initial begin
      int hold;
      int run;
      wait (!reset);
      @(posedge clock);
      forever begin
         hold = pick_gap();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8);
         repeat (run) @(posedge clock);
      end
   end

   // Watchdog: any handshake on either channel counts as progress.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no handshake for %0d cycles, %0d responses outstanding",
                     IDLE_LIMIT, pending);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      int length;
      int distinct;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // single-pixel image: flush of a one-index byte, color zero in entry 0
      send_pixel(32'h0000_0000, 1'b1, 1'b0);

      // four pixels ending on the last: the full byte goes out with done set
      send_pixel(32'hFFFF_FFFF, 1'b0, 1'b0);
      send_pixel(32'h0000_0000, 1'b0, 1'b0);
      send_pixel(32'hFFFF_FFFF, 1'b0, 1'b0);
      send_pixel(32'h1234_5678, 1'b1, 1'b0);

      // two full bytes mid-image, then a zero-padded partial byte
      send_pixel(32'h0000_0001, 1'b0, 1'b1);
      send_pixel(32'h0000_0002, 1'b0, 1'b1);
      send_pixel(32'h0000_0003, 1'b0, 1'b1);
      send_pixel(32'h0000_0004, 1'b0, 1'b1);
      send_pixel(32'h0000_0004, 1'b0, 1'b1);
      send_pixel(32'h0000_0003, 1'b0, 1'b1);
      send_pixel(32'h0000_0002, 1'b0, 1'b1);
      send_pixel(32'h0000_0001, 1'b0, 1'b1);
      send_pixel(32'h0000_0002, 1'b1, 1'b1);

      // fifth color after one full byte: later bytes withheld, done shows overflow
      send_pixel(32'h8000_0001, 1'b0, 1'b0);
      send_pixel(32'h8000_0000, 1'b0, 1'b0);
      send_pixel(32'h0000_0001, 1'b0, 1'b0);
      send_pixel(32'h7FFF_FFFF, 1'b0, 1'b0);
      send_pixel(32'hFFFF_FFFE, 1'b0, 1'b0);
      send_pixel(32'h8000_0001, 1'b1, 1'b0);

      // fifth color arrives on the last pixel itself
      send_pixel(32'hA5A5_A5A5, 1'b0, 1'b0);
      send_pixel(32'h5A5A_5A5A, 1'b0, 1'b0);
      send_pixel(32'hA5A5_A5A4, 1'b0, 1'b0);
      send_pixel(32'h0F0F_F0F0, 1'b0, 1'b0);
      send_pixel(32'hF0F0_0F0F, 1'b1, 1'b0);

      // Random images: mostly short, some long; about one in eight has more
      // colors than the palette holds.
      while (pixels_sent < PIXEL_TARGET) begin
         if ($urandom_range(0, 7) == 0) begin
            distinct = $urandom_range(5, 6);
            length   = $urandom_range(6, 40);
         end else begin
            distinct = $urandom_range(1, 4);
            length   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64)
                                                   : $urandom_range(1, 16);
         end
         send_image(length, distinct);
      end
      req_valid <= 1'b0;

      // the checker's count is registered, so it trails the final request
      @(posedge clock);

      // every image ended on a last pixel, so every prediction must come back
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d pixels in %0d images with one to six colors each,",
               pixels_sent, images_sent);
      $display("random gaps and stalls on both channels; %0d responses compared, %0d errors.",
               responses, errors);
      if (errors == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
